// ===== src/ltfop_pkg.sv =====
// shared types and constants of the large-tensor-first offset planner
package ltfop_pkg;

    localparam int ADDR_BITS  = 30;
    localparam int INDEX_BITS = 6;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_RK_I,
        ST_RK_I_GET,
        ST_RK_J,
        ST_RK_WR,
        ST_PL_ORD,
        ST_PL_CUR_ADDR,
        ST_PL_CUR_GET,
        ST_P1_ORD,
        ST_P1_ADDR,
        ST_P1_EVAL,
        ST_P1_DONE,
        ST_P2_ORD,
        ST_P2_ADDR,
        ST_P2_EVAL,
        ST_P3_ORD,
        ST_P3_ADDR,
        ST_P3_EVAL,
        ST_PL_WRITE,
        ST_OUT_RD,
        ST_OUT_LOAD
    } state_t;

endpackage

// ===== src/large_tensor_first_offset_planner_unit.sv =====
// top level of the large-tensor-first offset planner
//
// descriptor words (tensor_size, first_use, last_use, is_last) enter on the
// item_valid / item_ready channel, one per cycle while the block is loading.
// a word with is_last closes the set; words beyond MAX_TENSORS are dropped.
// after is_last the block drops item_ready and plans:
//   ranking by size compares every tensor against every other one,
//   placement walks the earlier tensors for each step in a first scan,
//   and in gap search mode may go on to search the gaps between them,
//   all through one shared compare unit walking the descriptor memory.
// results (tensor_index, address, last_result) leave on the result_valid /
// result_ready channel in load order, one word at a time through an
// output register; a stalled receiver holds the sequencer.
// once the last result is in the output register the block loads again.
// placement_mode is written with placement_mode_we; write it only while idle.
// reset returns to loading with an empty set and placement_mode at 1.
// the descriptor, order and address memories need no clearing pass.
module large_tensor_first_offset_planner_unit #(
    parameter int MAX_TENSORS = 64,
    parameter int SIZE_BITS   = 24,
    parameter int TIME_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [SIZE_BITS-1:0]               tensor_size,
    input  logic [TIME_BITS-1:0]               first_use,
    input  logic [TIME_BITS-1:0]               last_use,
    input  logic                               is_last,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [ltfop_pkg::INDEX_BITS-1:0]   tensor_index,
    output logic [ltfop_pkg::ADDR_BITS-1:0]    address,
    output logic                               last_result,
    input  logic                               placement_mode_we,
    input  logic                               placement_mode_wdata
);

    localparam int IW = $clog2(MAX_TENSORS);
    localparam int CW = $clog2(MAX_TENSORS + 1);
    localparam int AB = ltfop_pkg::ADDR_BITS;
    localparam int XB = ltfop_pkg::INDEX_BITS;
    localparam int DW = SIZE_BITS + 2 * TIME_BITS;
    localparam int EW = (SIZE_BITS > AB ? SIZE_BITS : AB) + 1;
    localparam logic [AB-1:0] ADDR_MAX = {AB{1'b1}};

    ltfop_pkg::state_t state_reg, state_next;

    logic               mode_reg;
    logic [CW-1:0]      load_cnt_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      s_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      rank_reg;
    logic [SIZE_BITS-1:0] size_i_reg;
    logic [IW-1:0]      cur_idx_reg;
    logic [SIZE_BITS-1:0] cur_size_reg;
    logic [TIME_BITS-1:0] cur_start_reg;
    logic [TIME_BITS-1:0] cur_end_reg;
    logic [EW-1:0]      top_reg;
    logic [AB:0]        bot_reg;
    logic [1:0]         cnt_reg;
    logic [EW-1:0]      lo_reg;
    logic [EW-1:0]      res_reg;
    logic               out_valid_reg;
    logic [XB-1:0]      out_index_reg;
    logic [AB-1:0]      out_addr_reg;
    logic               out_last_reg;

    // memory ports
    logic          desc_we;
    logic [IW-1:0] desc_waddr, desc_raddr;
    logic [DW-1:0] desc_wdata, desc_rdata;
    logic          addr_we;
    logic [IW-1:0] addr_waddr, addr_raddr;
    logic [AB-1:0] addr_wdata, addr_rdata;
    logic          order_we;
    logic [IW-1:0] order_waddr, order_raddr;
    logic [IW-1:0] order_wdata, order_rdata;

    ltfop_ram #(.WIDTH(DW), .DEPTH(MAX_TENSORS)) u_desc_ram (
        .clk   (clk),
        .we    (desc_we),
        .waddr (desc_waddr),
        .wdata (desc_wdata),
        .raddr (desc_raddr),
        .rdata (desc_rdata)
    );

    ltfop_ram #(.WIDTH(AB), .DEPTH(MAX_TENSORS)) u_addr_ram (
        .clk   (clk),
        .we    (addr_we),
        .waddr (addr_waddr),
        .wdata (addr_wdata),
        .raddr (addr_raddr),
        .rdata (addr_rdata)
    );

    ltfop_ram #(.WIDTH(IW), .DEPTH(MAX_TENSORS)) u_order_ram (
        .clk   (clk),
        .we    (order_we),
        .waddr (order_waddr),
        .wdata (order_wdata),
        .raddr (order_raddr),
        .rdata (order_rdata)
    );

    // shared compare unit on the descriptor being read
    logic [SIZE_BITS-1:0] rd_size;
    logic [TIME_BITS-1:0] rd_start, rd_end;
    logic                 ov;
    logic [EW-1:0]        rd_endpos;
    logic [EW:0]          hi;
    logic                 conflict;
    logic                 ahead;
    logic                 item_acc;
    logic                 out_free;
    logic                 need_search;
    logic [EW-1:0]        bot_ext, sz_ext, span;

    assign rd_size   = desc_rdata[DW-1 -: SIZE_BITS];
    assign rd_start  = desc_rdata[2*TIME_BITS-1 -: TIME_BITS];
    assign rd_end    = desc_rdata[TIME_BITS-1:0];
    assign ov        = (rd_start <= cur_end_reg) && (cur_start_reg <= rd_end);
    assign rd_endpos = EW'(addr_rdata) + EW'(rd_size);
    assign hi        = {1'b0, lo_reg} + (EW + 1)'(cur_size_reg);
    assign conflict  = ov && (lo_reg < rd_endpos) && (hi >= (EW + 1)'(addr_rdata));
    assign ahead     = (rd_size > size_i_reg) || ((rd_size == size_i_reg) && (j_reg < i_reg));
    assign item_acc  = item_valid && item_ready;
    assign out_free  = !out_valid_reg || result_ready;

    assign bot_ext = EW'(bot_reg);
    assign sz_ext  = EW'(cur_size_reg);
    assign span    = top_reg - bot_ext;
    assign need_search = mode_reg && (bot_ext < sz_ext) && (cnt_reg == 2'd2)
                         && (top_reg >= bot_ext) && (span >= sz_ext);

    assign item_ready   = (state_reg == ltfop_pkg::ST_LOAD);
    assign result_valid = out_valid_reg;
    assign tensor_index = out_index_reg;
    assign address      = out_addr_reg;
    assign last_result  = out_last_reg;

    assign desc_waddr  = load_cnt_reg[IW-1:0];
    assign desc_wdata  = {tensor_size, first_use, last_use};
    assign addr_waddr  = cur_idx_reg;
    assign addr_wdata  = (res_reg > EW'(ADDR_MAX)) ? ADDR_MAX : res_reg[AB-1:0];
    assign order_waddr = rank_reg[IW-1:0];
    assign order_wdata = i_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ltfop_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        desc_we     = 1'b0;
        addr_we     = 1'b0;
        order_we    = 1'b0;
        desc_raddr  = i_reg[IW-1:0];
        addr_raddr  = order_rdata;
        order_raddr = i_reg[IW-1:0];
        case (state_reg)
            ltfop_pkg::ST_LOAD:
            begin
                desc_we = item_acc && (load_cnt_reg < CW'(MAX_TENSORS));
                if (item_acc && is_last)
                begin
                    state_next = ltfop_pkg::ST_RK_I;
                end
            end
            ltfop_pkg::ST_RK_I:
            begin
                desc_raddr = i_reg[IW-1:0];
                state_next = ltfop_pkg::ST_RK_I_GET;
            end
            ltfop_pkg::ST_RK_I_GET:
            begin
                desc_raddr = '0;
                state_next = ltfop_pkg::ST_RK_J;
            end
            ltfop_pkg::ST_RK_J:
            begin
                desc_raddr = IW'(j_reg + CW'(1));
                if (j_reg + CW'(1) == n_reg)
                begin
                    state_next = ltfop_pkg::ST_RK_WR;
                end
            end
            ltfop_pkg::ST_RK_WR:
            begin
                order_we = 1'b1;
                if (i_reg + CW'(1) == n_reg)
                begin
                    state_next = ltfop_pkg::ST_PL_ORD;
                end
                else
                begin
                    state_next = ltfop_pkg::ST_RK_I;
                end
            end
            ltfop_pkg::ST_PL_ORD:
            begin
                order_raddr = s_reg[IW-1:0];
                state_next  = ltfop_pkg::ST_PL_CUR_ADDR;
            end
            ltfop_pkg::ST_PL_CUR_ADDR:
            begin
                desc_raddr = order_rdata;
                state_next = ltfop_pkg::ST_PL_CUR_GET;
            end
            ltfop_pkg::ST_PL_CUR_GET:
            begin
                if (s_reg == '0)
                begin
                    state_next = ltfop_pkg::ST_PL_WRITE;
                end
                else
                begin
                    state_next = ltfop_pkg::ST_P1_ORD;
                end
            end
            ltfop_pkg::ST_P1_ORD:
            begin
                order_raddr = i_reg[IW-1:0];
                state_next  = ltfop_pkg::ST_P1_ADDR;
            end
            ltfop_pkg::ST_P1_ADDR:
            begin
                desc_raddr = order_rdata;
                addr_raddr = order_rdata;
                state_next = ltfop_pkg::ST_P1_EVAL;
            end
            ltfop_pkg::ST_P1_EVAL:
            begin
                if (i_reg + CW'(1) == s_reg)
                begin
                    state_next = ltfop_pkg::ST_P1_DONE;
                end
                else
                begin
                    state_next = ltfop_pkg::ST_P1_ORD;
                end
            end
            ltfop_pkg::ST_P1_DONE:
            begin
                if (need_search)
                begin
                    state_next = ltfop_pkg::ST_P2_ORD;
                end
                else
                begin
                    state_next = ltfop_pkg::ST_PL_WRITE;
                end
            end
            ltfop_pkg::ST_P2_ORD:
            begin
                order_raddr = IW'(i_reg - CW'(1));
                state_next  = ltfop_pkg::ST_P2_ADDR;
            end
            ltfop_pkg::ST_P2_ADDR:
            begin
                desc_raddr = order_rdata;
                addr_raddr = order_rdata;
                state_next = ltfop_pkg::ST_P2_EVAL;
            end
            ltfop_pkg::ST_P2_EVAL:
            begin
                if (ov && (rd_endpos != top_reg))
                begin
                    state_next = ltfop_pkg::ST_P3_ORD;
                end
                else if (i_reg == CW'(1))
                begin
                    state_next = ltfop_pkg::ST_PL_WRITE;
                end
                else
                begin
                    state_next = ltfop_pkg::ST_P2_ORD;
                end
            end
            ltfop_pkg::ST_P3_ORD:
            begin
                order_raddr = j_reg[IW-1:0];
                state_next  = ltfop_pkg::ST_P3_ADDR;
            end
            ltfop_pkg::ST_P3_ADDR:
            begin
                desc_raddr = order_rdata;
                addr_raddr = order_rdata;
                state_next = ltfop_pkg::ST_P3_EVAL;
            end
            ltfop_pkg::ST_P3_EVAL:
            begin
                if (conflict)
                begin
                    if (i_reg == CW'(1))
                    begin
                        state_next = ltfop_pkg::ST_PL_WRITE;
                    end
                    else
                    begin
                        state_next = ltfop_pkg::ST_P2_ORD;
                    end
                end
                else if (j_reg + CW'(1) == s_reg)
                begin
                    state_next = ltfop_pkg::ST_PL_WRITE;
                end
                else
                begin
                    state_next = ltfop_pkg::ST_P3_ORD;
                end
            end
            ltfop_pkg::ST_PL_WRITE:
            begin
                addr_we = 1'b1;
                if (s_reg + CW'(1) == n_reg)
                begin
                    state_next = ltfop_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = ltfop_pkg::ST_PL_ORD;
                end
            end
            ltfop_pkg::ST_OUT_RD:
            begin
                addr_raddr = k_reg[IW-1:0];
                state_next = ltfop_pkg::ST_OUT_LOAD;
            end
            ltfop_pkg::ST_OUT_LOAD:
            begin
                addr_raddr = k_reg[IW-1:0];
                if (out_free)
                begin
                    if (k_reg + CW'(1) == n_reg)
                    begin
                        state_next = ltfop_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = ltfop_pkg::ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ltfop_pkg::ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b1;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (placement_mode_we)
            begin
                mode_reg <= placement_mode_wdata;
            end
            if (state_reg == ltfop_pkg::ST_LOAD && item_acc
                && load_cnt_reg < CW'(MAX_TENSORS))
            begin
                load_cnt_reg <= load_cnt_reg + CW'(1);
            end
            if (state_reg == ltfop_pkg::ST_OUT_LOAD && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (k_reg + CW'(1) == n_reg)
                begin
                    load_cnt_reg <= '0;
                end
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers of the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ltfop_pkg::ST_LOAD:
            begin
                i_reg <= '0;
                s_reg <= '0;
                k_reg <= '0;
                if (load_cnt_reg < CW'(MAX_TENSORS))
                begin
                    n_reg <= load_cnt_reg + CW'(1);
                end
                else
                begin
                    n_reg <= load_cnt_reg;
                end
            end
            ltfop_pkg::ST_RK_I_GET:
            begin
                size_i_reg <= rd_size;
                rank_reg   <= '0;
                j_reg      <= '0;
            end
            ltfop_pkg::ST_RK_J:
            begin
                rank_reg <= rank_reg + CW'(ahead);
                j_reg    <= j_reg + CW'(1);
            end
            ltfop_pkg::ST_RK_WR:
            begin
                if (i_reg + CW'(1) == n_reg)
                begin
                    i_reg <= '0;
                end
                else
                begin
                    i_reg <= i_reg + CW'(1);
                end
            end
            ltfop_pkg::ST_PL_CUR_ADDR:
            begin
                cur_idx_reg <= order_rdata;
            end
            ltfop_pkg::ST_PL_CUR_GET:
            begin
                cur_size_reg  <= rd_size;
                cur_start_reg <= rd_start;
                cur_end_reg   <= rd_end;
                top_reg       <= '0;
                bot_reg       <= '1;
                cnt_reg       <= '0;
                i_reg         <= '0;
                res_reg       <= '0;
            end
            ltfop_pkg::ST_P1_EVAL:
            begin
                if (ov)
                begin
                    if (rd_endpos > top_reg)
                    begin
                        top_reg <= rd_endpos;
                    end
                    if ((AB + 1)'(addr_rdata) < bot_reg)
                    begin
                        bot_reg <= (AB + 1)'(addr_rdata);
                    end
                    if (cnt_reg != 2'd2)
                    begin
                        cnt_reg <= cnt_reg + 2'd1;
                    end
                end
                i_reg <= i_reg + CW'(1);
            end
            ltfop_pkg::ST_P1_DONE:
            begin
                i_reg <= s_reg;
                // mode 1 goes to zero when the tensor fits below every overlapping tensor
                if (mode_reg && (bot_ext >= sz_ext))
                begin
                    res_reg <= '0;
                end
                else
                begin
                    res_reg <= top_reg;
                end
            end
            ltfop_pkg::ST_P2_EVAL:
            begin
                lo_reg <= rd_endpos;
                j_reg  <= '0;
                if (!(ov && (rd_endpos != top_reg)))
                begin
                    i_reg <= i_reg - CW'(1);
                end
            end
            ltfop_pkg::ST_P3_EVAL:
            begin
                if (conflict)
                begin
                    i_reg <= i_reg - CW'(1);
                end
                else if (j_reg + CW'(1) == s_reg)
                begin
                    res_reg <= lo_reg;
                end
                else
                begin
                    j_reg <= j_reg + CW'(1);
                end
            end
            ltfop_pkg::ST_PL_WRITE:
            begin
                s_reg <= s_reg + CW'(1);
            end
            ltfop_pkg::ST_OUT_LOAD:
            begin
                if (out_free)
                begin
                    out_index_reg <= XB'(k_reg);
                    out_addr_reg  <= addr_rdata;
                    out_last_reg  <= (k_reg + CW'(1) == n_reg);
                    k_reg         <= k_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== src/ltfop_ram.sv =====
// generic single write port ram with registered read
module ltfop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
